// File: rtl/kltd_pkg.sv
// ----------------------------------------------------------------------------
// Keyed level table package
// Shared constants, event codes and the beat types between front and back.
// ----------------------------------------------------------------------------
package kltd_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] EV_INSERTED = 3'd0;
    localparam logic [2:0] EV_UPDATED  = 3'd1;
    localparam logic [2:0] EV_FULL     = 3'd2;
    localparam logic [2:0] EV_SELECTED = 3'd3;
    localparam logic [2:0] EV_STARTED  = 3'd4;
    localparam logic [2:0] EV_DONE     = 3'd5;

    localparam logic [7:0] REQ_COUNT_RESET = 8'd21;
    localparam logic [7:0] BUSY_TICKS_RESET = 8'd30;

    localparam logic REG_REQUIRED_COUNT = 1'b0;
    localparam logic REG_BUSY_TICKS = 1'b1;

    typedef struct packed {
        logic        tick;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] level;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [63:0] target_hi;
        logic [63:0] target_lo;
        logic [15:0] target_level;
        logic [7:0]  entry_count;
    } result_t;

endpackage

// File: rtl/keyed_level_table_max_dispatch.sv
// ----------------------------------------------------------------------------
// Keyed level table with maximum-level dispatch
// A reading searches the table for its key and a selecting tick scans it for the
// maximum level; every item then passes through the finish and output states.
// One item is processed at a time, set by the single-port table scan: a new item
// is taken only in the idle state and only once any pending result is popped.
// Reset clears control state and restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module keyed_level_table_max_dispatch
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [15:0] level,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_res,
    output logic [63:0] target_hi,
    output logic [63:0] target_lo,
    output logic [15:0] target_level,
    output logic [7:0]  entry_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]        required_count_reg;
    logic [7:0]        busy_ticks_reg;
    kltd_pkg::item_t   in_item;
    kltd_pkg::item_t   q_item;
    logic              q_valid;
    logic              q_take;
    logic              res_valid;
    kltd_pkg::result_t res;

    assign pready          = 1'b1;
    assign in_item.tick    = mode;
    assign in_item.addr_hi = addr_hi;
    assign in_item.addr_lo = addr_lo;
    assign in_item.level   = level;

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                kltd_pkg::REG_REQUIRED_COUNT: prdata = {24'd0, required_count_reg};
                kltd_pkg::REG_BUSY_TICKS:     prdata = {24'd0, busy_ticks_reg};
                default:                      prdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_count_reg <= kltd_pkg::REQ_COUNT_RESET;
            busy_ticks_reg     <= kltd_pkg::BUSY_TICKS_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == kltd_pkg::REG_REQUIRED_COUNT)
            begin
                required_count_reg <= pwdata[7:0];
            end
            else
            begin
                busy_ticks_reg <= pwdata[7:0];
            end
        end
    end

    kltd_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    kltd_engine u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .required_count (required_count_reg),
        .busy_ticks     (busy_ticks_reg),
        .q_valid        (q_valid),
        .q_take         (q_take),
        .q_item         (q_item),
        .res_valid      (res_valid),
        .res_take       (pop),
        .res            (res)
    );

    assign empty        = !res_valid;
    assign event_res    = res.event_res;
    assign target_hi    = res.target_hi;
    assign target_lo    = res.target_lo;
    assign target_level = res.target_level;
    assign entry_count  = res.entry_count;

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (event_res <= kltd_pkg::EV_DONE))
        else $error("Result event code out of range.");

    a_entry_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (entry_count <= 8'(kltd_pkg::TABLE_DEPTH)))
        else $error("Entry count exceeds table depth.");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res == kltd_pkg::EV_DONE) |-> (entry_count == 8'd0))
        else $error("Done beat reports a nonempty table.");

endmodule

// File: rtl/kltd_front.sv
// ----------------------------------------------------------------------------
// Keyed level table front end
// Accepts input beats and queues them for the table engine.
// ----------------------------------------------------------------------------
module kltd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  kltd_pkg::item_t in_item,
    output logic            q_valid,
    input  logic            q_take,
    output kltd_pkg::item_t q_item
);

    kltd_pkg::item_t             mem_reg [kltd_pkg::QUEUE_DEPTH];
    logic [kltd_pkg::QPTR_W-1:0] wr_reg;
    logic [kltd_pkg::QPTR_W-1:0] rd_reg;
    logic [kltd_pkg::QPTR_W:0]   cnt_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (cnt_reg == (kltd_pkg::QPTR_W+1)'(kltd_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (kltd_pkg::QPTR_W+1)'(do_push)
                               - (kltd_pkg::QPTR_W+1)'(do_pop);
        end
    end

endmodule

// File: rtl/kltd_engine.sv
// ----------------------------------------------------------------------------
// Keyed level table engine
// Scans the table one entry a cycle for key search and maximum selection.
// ----------------------------------------------------------------------------
module kltd_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         required_count,
    input  logic [7:0]         busy_ticks,
    input  logic               q_valid,
    output logic               q_take,
    input  kltd_pkg::item_t    q_item,
    output logic               res_valid,
    input  logic               res_take,
    output kltd_pkg::result_t  res
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_MAX    = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [63:0] khi_mem [kltd_pkg::TABLE_DEPTH];
    logic [63:0] klo_mem [kltd_pkg::TABLE_DEPTH];
    logic [15:0] lvl_mem [kltd_pkg::TABLE_DEPTH];

    logic [2:0]                 state_reg;
    kltd_pkg::item_t            item_reg;
    logic [kltd_pkg::CNT_W-1:0] filled_reg;
    logic [kltd_pkg::CNT_W-1:0] idx_reg;
    logic                       rd_ok_reg;
    logic [kltd_pkg::IDX_W-1:0] rd_idx_reg;
    logic [63:0]                rd_hi_reg;
    logic [63:0]                rd_lo_reg;
    logic [15:0]                rd_lvl_reg;
    logic                       hit_reg;
    logic [kltd_pkg::IDX_W-1:0] hit_idx_reg;
    logic [63:0]                best_hi_reg;
    logic [63:0]                best_lo_reg;
    logic [15:0]                best_lvl_reg;
    logic                       pending_reg;
    logic                       active_reg;
    logic [63:0]                chosen_hi_reg;
    logic [63:0]                chosen_lo_reg;
    logic [7:0]                 countdown_reg;
    logic                       res_valid_reg;
    kltd_pkg::result_t          res_reg;
    logic                       wr_en;
    logic [kltd_pkg::IDX_W-1:0] wr_idx;
    logic                       start_sel;

    assign q_take    = (state_reg == ST_IDLE) && q_valid && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign start_sel = (filled_reg != '0) &&
                       ({{(16-kltd_pkg::CNT_W){1'b0}}, filled_reg} ==
                        {8'd0, required_count});

    always_comb
    begin
        wr_en  = (state_reg == ST_FINISH) && !item_reg.tick &&
                 (hit_reg || (filled_reg != kltd_pkg::CNT_W'(kltd_pkg::TABLE_DEPTH)));
        wr_idx = hit_reg ? hit_idx_reg : filled_reg[kltd_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            khi_mem[wr_idx] <= item_reg.addr_hi;
            klo_mem[wr_idx] <= item_reg.addr_lo;
            lvl_mem[wr_idx] <= item_reg.level;
        end
        rd_hi_reg  <= khi_mem[idx_reg[kltd_pkg::IDX_W-1:0]];
        rd_lo_reg  <= klo_mem[idx_reg[kltd_pkg::IDX_W-1:0]];
        rd_lvl_reg <= lvl_mem[idx_reg[kltd_pkg::IDX_W-1:0]];
        rd_idx_reg <= idx_reg[kltd_pkg::IDX_W-1:0];
        if (q_take)
        begin
            item_reg <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            idx_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            best_hi_reg   <= '0;
            best_lo_reg   <= '0;
            best_lvl_reg  <= '0;
            pending_reg   <= 1'b0;
            active_reg    <= 1'b0;
            chosen_hi_reg <= '0;
            chosen_lo_reg <= '0;
            countdown_reg <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && res_take)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg   <= '0;
                    rd_ok_reg <= 1'b0;
                    hit_reg   <= 1'b0;
                    if (q_take)
                    begin
                        if (!q_item.tick)
                        begin
                            state_reg <= ST_SEARCH;
                        end
                        else if (active_reg || pending_reg || !start_sel)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_MAX;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (rd_ok_reg && !hit_reg && rd_hi_reg == item_reg.addr_hi &&
                        rd_lo_reg == item_reg.addr_lo)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                    rd_ok_reg <= (idx_reg < filled_reg);
                    if (idx_reg < filled_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_MAX:
                begin
                    if (rd_ok_reg && (rd_idx_reg == '0 || rd_lvl_reg > best_lvl_reg))
                    begin
                        best_hi_reg  <= rd_hi_reg;
                        best_lo_reg  <= rd_lo_reg;
                        best_lvl_reg <= rd_lvl_reg;
                    end
                    rd_ok_reg <= (idx_reg < filled_reg);
                    if (idx_reg < filled_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    state_reg <= ST_OUT;
                    if (!item_reg.tick)
                    begin
                        res_reg.target_hi    <= item_reg.addr_hi;
                        res_reg.target_lo    <= item_reg.addr_lo;
                        res_reg.target_level <= item_reg.level;
                        res_valid_reg        <= 1'b1;
                        if (hit_reg)
                        begin
                            res_reg.event_res   <= kltd_pkg::EV_UPDATED;
                            res_reg.entry_count <= 8'(filled_reg);
                        end
                        else if (filled_reg != kltd_pkg::CNT_W'(kltd_pkg::TABLE_DEPTH))
                        begin
                            res_reg.event_res   <= kltd_pkg::EV_INSERTED;
                            filled_reg          <= filled_reg + 1'b1;
                            res_reg.entry_count <= 8'(filled_reg + 1'b1);
                        end
                        else
                        begin
                            res_reg.event_res   <= kltd_pkg::EV_FULL;
                            res_reg.entry_count <= 8'(filled_reg);
                        end
                    end
                    else if (active_reg)
                    begin
                        if (countdown_reg <= 8'd1)
                        begin
                            countdown_reg        <= '0;
                            active_reg           <= 1'b0;
                            pending_reg          <= 1'b0;
                            filled_reg           <= '0;
                            res_reg.event_res    <= kltd_pkg::EV_DONE;
                            res_reg.target_hi    <= chosen_hi_reg;
                            res_reg.target_lo    <= chosen_lo_reg;
                            res_reg.target_level <= '0;
                            res_reg.entry_count  <= '0;
                            res_valid_reg        <= 1'b1;
                        end
                        else
                        begin
                            countdown_reg <= countdown_reg - 8'd1;
                        end
                    end
                    else if (pending_reg)
                    begin
                        pending_reg          <= 1'b0;
                        active_reg           <= 1'b1;
                        countdown_reg        <= busy_ticks;
                        res_reg.event_res    <= kltd_pkg::EV_STARTED;
                        res_reg.target_hi    <= chosen_hi_reg;
                        res_reg.target_lo    <= chosen_lo_reg;
                        res_reg.target_level <= '0;
                        res_reg.entry_count  <= 8'(filled_reg);
                        res_valid_reg        <= 1'b1;
                    end
                    else if (start_sel)
                    begin
                        chosen_hi_reg        <= best_hi_reg;
                        chosen_lo_reg        <= best_lo_reg;
                        pending_reg          <= 1'b1;
                        res_reg.event_res    <= kltd_pkg::EV_SELECTED;
                        res_reg.target_hi    <= best_hi_reg;
                        res_reg.target_lo    <= best_lo_reg;
                        res_reg.target_level <= best_lvl_reg;
                        res_reg.entry_count  <= 8'(filled_reg);
                        res_valid_reg        <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/kltd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed level table checker
// Watches the item, result and register channels of the block. Each accepted
// item runs through a behavioral copy of the node table and the dispatch
// state, and the result it causes is queued. Each accepted result beat is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module kltd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        mode,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [15:0] level,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  event_res,
    input  logic [63:0] target_hi,
    input  logic [63:0] target_lo,
    input  logic [15:0] target_level,
    input  logic [7:0]  entry_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    logic [63:0]       node_hi [kltd_pkg::TABLE_DEPTH];
    logic [63:0]       node_lo [kltd_pkg::TABLE_DEPTH];
    logic [15:0]       node_level [kltd_pkg::TABLE_DEPTH];
    int                node_count;
    bit                dispatch_pending;
    bit                dispatch_active;
    logic [63:0]       pick_hi;
    logic [63:0]       pick_lo;
    logic [7:0]        ticks_left;
    logic [7:0]        need_count;
    logic [7:0]        dispatch_ticks;
    kltd_pkg::result_t expected_q[$];

    function automatic kltd_pkg::result_t make_result(logic [2:0] ev, logic [63:0] hi,
                                                      logic [63:0] lo, logic [15:0] lvl);
        kltd_pkg::result_t r;
        r.event_res = ev;
        r.target_hi = hi;
        r.target_lo = lo;
        r.target_level = lvl;
        r.entry_count = node_count[7:0];
        return r;
    endfunction

    function automatic bit apply_reading(kltd_pkg::item_t it, output kltd_pkg::result_t r);
        for (int i = 0; i < node_count; i++)
        begin
            if (node_hi[i] == it.addr_hi && node_lo[i] == it.addr_lo)
            begin
                node_level[i] = it.level;
                r = make_result(kltd_pkg::EV_UPDATED, it.addr_hi, it.addr_lo, it.level);
                return 1'b1;
            end
        end
        if (node_count < kltd_pkg::TABLE_DEPTH)
        begin
            node_hi[node_count] = it.addr_hi;
            node_lo[node_count] = it.addr_lo;
            node_level[node_count] = it.level;
            node_count++;
            r = make_result(kltd_pkg::EV_INSERTED, it.addr_hi, it.addr_lo, it.level);
        end
        else
            r = make_result(kltd_pkg::EV_FULL, it.addr_hi, it.addr_lo, it.level);
        return 1'b1;
    endfunction

    function automatic bit apply_tick(output kltd_pkg::result_t r);
        int best;
        if (dispatch_active)
        begin
            if (ticks_left <= 8'd1)
            begin
                ticks_left = 8'd0;
                dispatch_active = 1'b0;
                dispatch_pending = 1'b0;
                node_count = 0;
                r = make_result(kltd_pkg::EV_DONE, pick_hi, pick_lo, 16'd0);
                return 1'b1;
            end
            ticks_left--;
            return 1'b0;
        end
        if (dispatch_pending)
        begin
            dispatch_pending = 1'b0;
            dispatch_active = 1'b1;
            ticks_left = dispatch_ticks;
            r = make_result(kltd_pkg::EV_STARTED, pick_hi, pick_lo, 16'd0);
            return 1'b1;
        end
        if (node_count > 0 && node_count == int'(need_count))
        begin
            best = 0;
            for (int i = 1; i < node_count; i++)
            begin
                if (node_level[i] > node_level[best])
                    best = i;
            end
            pick_hi = node_hi[best];
            pick_lo = node_lo[best];
            dispatch_pending = 1'b1;
            r = make_result(kltd_pkg::EV_SELECTED, pick_hi, pick_lo, node_level[best]);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        kltd_pkg::item_t   beat_in;
        kltd_pkg::result_t want;
        kltd_pkg::result_t got;
        bit                produced;
        if (!rst_n)
        begin
            mismatches = 0;
            node_count = 0;
            dispatch_pending = 1'b0;
            dispatch_active = 1'b0;
            pick_hi = '0;
            pick_lo = '0;
            ticks_left = '0;
            need_count = kltd_pkg::REQ_COUNT_RESET;
            dispatch_ticks = kltd_pkg::BUSY_TICKS_RESET;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[1:0] == 2'b00 && paddr[2] == kltd_pkg::REG_REQUIRED_COUNT)
                    need_count = pwdata[7:0];
                else if (paddr[1:0] == 2'b00 && paddr[2] == kltd_pkg::REG_BUSY_TICKS)
                    dispatch_ticks = pwdata[7:0];
            end
            if (push && !full)
            begin
                beat_in.tick = mode;
                beat_in.addr_hi = addr_hi;
                beat_in.addr_lo = addr_lo;
                beat_in.level = level;
                if (beat_in.tick)
                    produced = apply_tick(want);
                else
                    produced = apply_reading(beat_in, want);
                if (produced)
                    expected_q.push_back(want);
            end
            if (pop && !empty)
            begin
                got.event_res = event_res;
                got.target_hi = target_hi;
                got.target_lo = target_lo;
                got.target_level = target_level;
                got.entry_count = entry_count;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat ev=%0d hi=%h lo=%h lvl=%0d cnt=%0d",
                                 $realtime, got.event_res, got.target_hi, got.target_lo,
                                 got.target_level, got.entry_count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected ev=%0d hi=%h lo=%h lvl=%0d cnt=%0d",
                                     want.event_res, want.target_hi, want.target_lo,
                                     want.target_level, want.entry_count);
                            $display("  actual   ev=%0d hi=%h lo=%h lvl=%0d cnt=%0d",
                                     got.event_res, got.target_hi, got.target_lo,
                                     got.target_level, got.entry_count);
                        end
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed level table testbench
// Drives readings and ticks in whole fill, select and dispatch cycles with
// random addresses, levels and register settings, plus overfilled tables and
// a full table, under random gaps on both sides. The checker decides
// correctness; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic MODE_READING = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam int SETTLE_CYCLES = 160;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        mode = 1'b0;
    logic [63:0] addr_hi = '0;
    logic [63:0] addr_lo = '0;
    logic [15:0] level = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  event_res;
    logic [63:0] target_hi;
    logic [63:0] target_lo;
    logic [15:0] target_level;
    logic [7:0]  entry_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          pop_stall = 0;
    bit          pop_eager = 1'b0;
    logic [127:0] live_keys[$];

    always #6 clk = ~clk;

    keyed_level_table_max_dispatch uut (.*);

    kltd_checker u_checker (.*);

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if ($urandom_range(0, 299) == 0)
                pop_eager = ~pop_eager;
            if (pop_stall > 0)
            begin
                pop_stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (!pop_eager && $urandom_range(0, 3) == 0)
                    pop_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("keyed_level_table_max_dispatch regression: fail");
            $finish;
        end
    end

    task automatic send_beat(logic m, logic [63:0] hi, logic [63:0] lo, logic [15:0] lvl);
        int gap;
        gap = 0;
        if ($urandom_range(0, 9) < 3)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        mode <= m;
        addr_hi <= hi;
        addr_lo <= lo;
        level <= lvl;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'(100 + $urandom_range(0, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit is_live(logic [127:0] k);
        foreach (live_keys[i])
        begin
            if (live_keys[i] == k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_tick();
        send_beat(MODE_TICK, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
    endtask

    task automatic send_new_reading();
        logic [127:0] k;
        do
        begin
            k = {$urandom, $urandom, $urandom, $urandom};
            if (live_keys.size() > 0 && $urandom_range(0, 4) == 0)
                k[127:64] = live_keys[$urandom_range(0, live_keys.size() - 1)][127:64];
            else if ($urandom_range(0, 9) == 0)
                k[63:0] = '1;
        end
        while (is_live(k));
        if (live_keys.size() < kltd_pkg::TABLE_DEPTH)
            live_keys.push_back(k);
        send_beat(MODE_READING, k[127:64], k[63:0], pick_level());
    endtask

    task automatic send_update();
        logic [127:0] k;
        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        send_beat(MODE_READING, k[127:64], k[63:0], pick_level());
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic regsel, logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_dispatch(int need, int ticks, bit overfill);
        int target;
        write_reg(kltd_pkg::REG_REQUIRED_COUNT, 8'(need));
        write_reg(kltd_pkg::REG_BUSY_TICKS, 8'(ticks));
        live_keys.delete();
        target = overfill ? need + $urandom_range(1, 3) : need;
        if (target > kltd_pkg::TABLE_DEPTH)
            target = kltd_pkg::TABLE_DEPTH;
        while (live_keys.size() < target)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: if (live_keys.size() > 0) send_update();
                5, 6: if (live_keys.size() < need) send_tick();
                default: send_new_reading();
            endcase
        end
        if (target == kltd_pkg::TABLE_DEPTH)
        begin
            send_new_reading();
            send_update();
        end
        if (overfill)
        begin
            send_tick();
            send_tick();
            settle();
            write_reg(kltd_pkg::REG_REQUIRED_COUNT, 8'(live_keys.size()));
        end
        send_tick();
        if ($urandom_range(0, 1) == 0)
            send_update();
        send_tick();
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1) == 0 || live_keys.size() >= kltd_pkg::TABLE_DEPTH)
                    send_update();
                else
                    send_new_reading();
            end
            send_tick();
        end
        send_tick();
        live_keys.delete();
        settle();
    endtask

    initial
    begin
        int need;
        int ticks;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(kltd_pkg::REG_REQUIRED_COUNT, 8'd3);
        write_reg(kltd_pkg::REG_BUSY_TICKS, 8'd1);
        send_tick();
        send_beat(MODE_READING, 64'd0, 64'd0, 16'd0);
        send_beat(MODE_READING, '1, '1, 16'hFFFF);
        send_beat(MODE_READING, 64'd0, 64'd0, 16'hFFFF);
        send_tick();
        send_beat(MODE_READING, 64'd0, 64'd1, 16'hFFFF);
        send_tick();
        send_beat(MODE_READING, '1, 64'd0, 16'd7);
        send_beat(MODE_READING, 64'd0, 64'd0, 16'd5);
        send_tick();
        send_beat(MODE_READING, 64'd5, 64'd5, 16'd9);
        send_tick();
        send_tick();
        settle();
        write_reg(kltd_pkg::REG_REQUIRED_COUNT, 8'd200);
        send_beat(MODE_READING, 64'h8000_0000_0000_0000, 64'd3, 16'd1);
        send_beat(MODE_READING, 64'd3, 64'h8000_0000_0000_0000, 16'd1);
        send_tick();
        settle();
        write_reg(kltd_pkg::REG_REQUIRED_COUNT, 8'd0);
        send_tick();
        settle();
        write_reg(kltd_pkg::REG_REQUIRED_COUNT, 8'd2);
        send_tick();
        send_tick();
        send_tick();
        settle();

        run_dispatch(kltd_pkg::TABLE_DEPTH, 255, 1'b0);
        run_dispatch(1, 1, 1'b0);
        while (items_sent < 800)
        begin
            need = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            if ($urandom_range(0, 29) == 0)
                ticks = 255;
            run_dispatch(need, ticks, $urandom_range(0, 4) == 0);
        end

        if (mismatches == 0 && outstanding == 0)
            $display("keyed_level_table_max_dispatch regression: pass");
        else
            $display("keyed_level_table_max_dispatch regression: fail");
        $finish;
    end

endmodule
